// File: sv/ptns_pkg.sv
// Shared types and constants for the point table nearest search block.
`default_nettype none
package ptns_pkg;

    localparam int OP_BITS     = 3;
    localparam int STATUS_BITS = 2;
    localparam int ANSWER_BITS = 20;
    localparam int SLOT_BITS   = 20;
    localparam int RADIUS_BITS = 50;

    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 50'd42949673;

    typedef enum logic [OP_BITS-1:0] {
        OP_CLEAR   = 3'd0,
        OP_INSERT  = 3'd1,
        OP_READ    = 3'd2,
        OP_FIRST   = 3'd3,
        OP_NEAREST = 3'd4
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

    // Status of the distance pipeline as seen by the sequencer
    typedef struct packed {
        logic busy;
        logic hit_valid;
    } pipe_stat_t;

endpackage
`default_nettype wire

// File: sv/ptns_if.sv
// Handshake interfaces for the request, response and radius channels.
`default_nettype none
interface ptns_req_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic [ptns_pkg::OP_BITS-1:0] op;
    logic signed [COORD_BITS-1:0] x_coord;
    logic signed [COORD_BITS-1:0] y_coord;
    logic [ptns_pkg::SLOT_BITS-1:0] tag_or_slot;

    modport source (output valid, output op, output x_coord, output y_coord,
                    output tag_or_slot, input ready);
    modport sink   (input valid, input op, input x_coord, input y_coord,
                    input tag_or_slot, output ready);
endinterface

interface ptns_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [ptns_pkg::STATUS_BITS-1:0] status;
    logic [ptns_pkg::ANSWER_BITS-1:0] answer;

    modport source (output valid, output status, output answer, input ready);
    modport sink   (input valid, input status, input answer, output ready);
endinterface

interface ptns_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ptns_pkg::RADIUS_BITS-1:0] radius_squared;

    modport source (output valid, output radius_squared, input ready);
    modport sink   (input valid, input radius_squared, output ready);
endinterface
`default_nettype wire

// File: sv/point_table_nearest_search.sv
// Top level of the point table with brute-force nearest search.
//
//  channel | dir | beat contents                          | accepted when
//  --------+-----+----------------------------------------+----------------------
//  req     | in  | op, x_coord, y_coord, tag_or_slot      | req.valid & req.ready
//  rsp     | out | status, answer                         | rsp.valid & rsp.ready
//  cfg     | in  | radius_squared                         | cfg.valid & cfg.ready
//
// Clear, insert and unused ops skip the scan and go straight to the response stage.
// Read at slot scans one slot; first within radius and nearest scan up to fill_count
// slots, paced by the single memory read port delivering one point per cycle.
// Reset empties the table by clearing the fill count; memory is not swept.
// A finished response waits in the output register; the next request beat is
// taken meanwhile, and the one after waits until the response is handed off.
`default_nettype none
module point_table_nearest_search #(
    parameter int CAPACITY   = 4096,
    parameter int COORD_BITS = 24,
    parameter int TAG_BITS   = 20
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ptns_req_if.sink   req,
    ptns_rsp_if.source rsp,
    ptns_cfg_if.sink   cfg
);
    import ptns_pkg::*;

    localparam int ADDR_BITS = $clog2(CAPACITY);
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);
    localparam int DIST_BITS = 2 * COORD_BITS + 3;
    localparam int WORD_BITS = 2 * COORD_BITS + TAG_BITS;

    logic                  mem_we, issue_valid;
    logic [ADDR_BITS-1:0]  mem_waddr, issue_slot, hit_slot;
    logic [WORD_BITS-1:0]  mem_wdata, mem_rdata;
    logic [COORD_BITS-1:0] qx, qy;
    logic [DIST_BITS-1:0]  hit_dist;
    logic [TAG_BITS-1:0]   hit_tag;
    pipe_stat_t            pipe;

    ptns_ctrl #(
        .CAPACITY   (CAPACITY),
        .COORD_BITS (COORD_BITS),
        .TAG_BITS   (TAG_BITS),
        .ADDR_BITS  (ADDR_BITS),
        .CNT_BITS   (CNT_BITS),
        .DIST_BITS  (DIST_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg         (cfg),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .issue_valid (issue_valid),
        .issue_slot  (issue_slot),
        .qx          (qx),
        .qy          (qy),
        .pipe        (pipe),
        .hit_dist    (hit_dist),
        .hit_slot    (hit_slot),
        .hit_tag     (hit_tag)
    );

    ptns_mem #(
        .DEPTH     (CAPACITY),
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (WORD_BITS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (issue_valid),
        .raddr (issue_slot),
        .rdata (mem_rdata)
    );

    ptns_dist #(
        .COORD_BITS (COORD_BITS),
        .TAG_BITS   (TAG_BITS),
        .ADDR_BITS  (ADDR_BITS),
        .DIST_BITS  (DIST_BITS)
    ) u_dist (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue_valid (issue_valid),
        .issue_slot  (issue_slot),
        .px          (mem_rdata[WORD_BITS-1 -: COORD_BITS]),
        .py          (mem_rdata[TAG_BITS +: COORD_BITS]),
        .ptag        (mem_rdata[TAG_BITS-1:0]),
        .qx          (qx),
        .qy          (qy),
        .pipe        (pipe),
        .hit_dist    (hit_dist),
        .hit_slot    (hit_slot),
        .hit_tag     (hit_tag)
    );

endmodule
`default_nettype wire

// File: sv/ptns_mem.sv
// Point memory: one write port, one read port with registered read data.
`default_nettype none
module ptns_mem #(
    parameter int DEPTH      = 4096,
    parameter int ADDR_BITS  = 12,
    parameter int DATA_BITS  = 68
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [DATA_BITS-1:0] wdata,
    input  wire logic                 re,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem_q [DEPTH];
    logic [DATA_BITS-1:0] rdata_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_q[waddr] <= wdata;
        end
    end

    // Read one entry, data valid next cycle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_q[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: sv/ptns_dist.sv
// Distance pipeline: difference and magnitude, square, sum of squares.
`default_nettype none
module ptns_dist #(
    parameter int COORD_BITS = 24,
    parameter int TAG_BITS   = 20,
    parameter int ADDR_BITS  = 12,
    parameter int DIST_BITS  = 2 * COORD_BITS + 3
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  issue_valid,
    input  wire logic [ADDR_BITS-1:0]  issue_slot,
    input  wire logic [COORD_BITS-1:0] px,
    input  wire logic [COORD_BITS-1:0] py,
    input  wire logic [TAG_BITS-1:0]   ptag,
    input  wire logic [COORD_BITS-1:0] qx,
    input  wire logic [COORD_BITS-1:0] qy,
    output ptns_pkg::pipe_stat_t       pipe,
    output logic [DIST_BITS-1:0]       hit_dist,
    output logic [ADDR_BITS-1:0]       hit_slot,
    output logic [TAG_BITS-1:0]        hit_tag
);
    import ptns_pkg::*;

    localparam int MAG_BITS = COORD_BITS + 1;
    localparam int SQ_BITS  = 2 * MAG_BITS;

    logic                 v0_reg, v1_reg, v2_reg, v3_reg;
    logic [ADDR_BITS-1:0] slot0_reg, slot1_reg, slot2_reg, slot3_reg;
    logic [TAG_BITS-1:0]  tag1_reg, tag2_reg, tag3_reg;
    logic [MAG_BITS-1:0]  dx, dy, adx_next, ady_next, adx1_reg, ady1_reg;
    logic [SQ_BITS-1:0]   sqx_next, sqy_next, sqx2_reg, sqy2_reg;
    logic [DIST_BITS-1:0] dist_next, dist3_reg;

    // Difference and magnitude of each axis
    always_comb
    begin
        dx       = {px[COORD_BITS-1], px} - {qx[COORD_BITS-1], qx};
        dy       = {py[COORD_BITS-1], py} - {qy[COORD_BITS-1], qy};
        adx_next = dx[MAG_BITS-1] ? (~dx + 1'b1) : dx;
        ady_next = dy[MAG_BITS-1] ? (~dy + 1'b1) : dy;
    end

    // Square each magnitude
    always_comb
    begin
        sqx_next = SQ_BITS'(adx1_reg) * SQ_BITS'(adx1_reg);
        sqy_next = SQ_BITS'(ady1_reg) * SQ_BITS'(ady1_reg);
    end

    // Sum the squares
    assign dist_next = DIST_BITS'(sqx2_reg) + DIST_BITS'(sqy2_reg);

    // Advance stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= issue_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Advance stage payload
    always_ff @(posedge clk)
    begin
        slot0_reg <= issue_slot;
        slot1_reg <= slot0_reg;
        tag1_reg  <= ptag;
        adx1_reg  <= adx_next;
        ady1_reg  <= ady_next;
        slot2_reg <= slot1_reg;
        tag2_reg  <= tag1_reg;
        sqx2_reg  <= sqx_next;
        sqy2_reg  <= sqy_next;
        slot3_reg <= slot2_reg;
        tag3_reg  <= tag2_reg;
        dist3_reg <= dist_next;
    end

    assign pipe.busy      = v0_reg | v1_reg | v2_reg | v3_reg;
    assign pipe.hit_valid = v3_reg;
    assign hit_dist       = dist3_reg;
    assign hit_slot       = slot3_reg;
    assign hit_tag        = tag3_reg;

endmodule
`default_nettype wire

// File: sv/ptns_ctrl.sv
// Sequencer: op decode, fill count, scan of the table, best tracking, response.
`default_nettype none
module ptns_ctrl #(
    parameter int CAPACITY   = 4096,
    parameter int COORD_BITS = 24,
    parameter int TAG_BITS   = 20,
    parameter int ADDR_BITS  = 12,
    parameter int CNT_BITS   = 13,
    parameter int DIST_BITS  = 2 * COORD_BITS + 3
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    ptns_req_if.sink                           req,
    ptns_rsp_if.source                         rsp,
    ptns_cfg_if.sink                           cfg,
    output logic                               mem_we,
    output logic [ADDR_BITS-1:0]               mem_waddr,
    output logic [2*COORD_BITS+TAG_BITS-1:0]   mem_wdata,
    output logic                               issue_valid,
    output logic [ADDR_BITS-1:0]               issue_slot,
    output logic [COORD_BITS-1:0]              qx,
    output logic [COORD_BITS-1:0]              qy,
    input  wire ptns_pkg::pipe_stat_t          pipe,
    input  wire logic [DIST_BITS-1:0]          hit_dist,
    input  wire logic [ADDR_BITS-1:0]          hit_slot,
    input  wire logic [TAG_BITS-1:0]           hit_tag
);
    import ptns_pkg::*;

    localparam int SC_BITS  = (SLOT_BITS > CNT_BITS) ? SLOT_BITS : CNT_BITS;
    localparam int CMP_BITS = (DIST_BITS > RADIUS_BITS) ? DIST_BITS : RADIUS_BITS;

    state_t                  state_reg, state_next;
    op_t                     op_reg, op_next;
    logic [CNT_BITS-1:0]     fill_reg, fill_next;
    logic [CNT_BITS-1:0]     issue_reg, issue_next;
    logic [CNT_BITS-1:0]     limit_reg, limit_next;
    logic [RADIUS_BITS-1:0]  radius_reg;
    logic                    found_reg, found_next;
    logic [DIST_BITS-1:0]    best_reg, best_next;
    status_t                 status_reg, status_next;
    logic [ANSWER_BITS-1:0]  answer_reg, answer_next;
    logic [COORD_BITS-1:0]   qx_reg, qx_next, qy_reg, qy_next;
    logic                    rsp_valid_reg;
    status_t                 rsp_status_reg;
    logic [ANSWER_BITS-1:0]  rsp_answer_reg;
    logic                    accept, load_rsp, in_range, near_radius, near_best;
    logic [COORD_BITS-1:0]   in_x, in_y;

    assign accept     = req.valid && req.ready;
    assign req.ready  = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;
    assign in_x       = COORD_BITS'(req.x_coord);
    assign in_y       = COORD_BITS'(req.y_coord);
    assign in_range   = SC_BITS'(req.tag_or_slot) < SC_BITS'(fill_reg);
    assign near_radius = CMP_BITS'(hit_dist) < CMP_BITS'(radius_reg);
    assign near_best   = hit_dist < best_reg;
    assign load_rsp    = (state_reg == S_DONE) && (!rsp_valid_reg || rsp.ready);

    // Append an inserted point at the fill count
    assign mem_we    = accept && (op_t'(req.op) == OP_INSERT)
                       && (fill_reg != CNT_BITS'(CAPACITY));
    assign mem_waddr = fill_reg[ADDR_BITS-1:0];
    assign mem_wdata = {in_x, in_y, TAG_BITS'(req.tag_or_slot)};

    // Issue one table read per cycle until the limit or a radius hit
    assign issue_valid = (state_reg == S_SCAN) && (issue_reg < limit_reg)
                         && !((op_reg == OP_FIRST) && found_reg);
    assign issue_slot  = issue_reg[ADDR_BITS-1:0];
    assign qx          = qx_reg;
    assign qy          = qy_reg;

    // Next state, op setup and result tracking
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        fill_next   = fill_reg;
        issue_next  = issue_reg;
        limit_next  = limit_reg;
        found_next  = found_reg;
        best_next   = best_reg;
        status_next = status_reg;
        answer_next = answer_reg;
        qx_next     = qx_reg;
        qy_next     = qy_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = op_t'(req.op);
                    qx_next     = in_x;
                    qy_next     = in_y;
                    found_next  = 1'b0;
                    status_next = ST_OK;
                    answer_next = '0;
                    state_next  = S_DONE;
                    unique case (op_t'(req.op)) inside
                        OP_CLEAR:
                        begin
                            fill_next = '0;
                        end
                        OP_INSERT:
                        begin
                            if (fill_reg == CNT_BITS'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        OP_READ:
                        begin
                            if (!in_range)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                issue_next = CNT_BITS'(req.tag_or_slot);
                                limit_next = CNT_BITS'(req.tag_or_slot) + 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        OP_FIRST, OP_NEAREST:
                        begin
                            status_next = ST_NOT_FOUND;
                            if (fill_reg != '0)
                            begin
                                issue_next = '0;
                                limit_next = fill_reg;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (issue_valid)
                begin
                    issue_next = issue_reg + 1'b1;
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!pipe.busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load_rsp)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Fold each finished distance into the result
        if (pipe.hit_valid)
        begin
            case (op_reg)
                OP_READ:
                begin
                    status_next = ST_OK;
                    answer_next = ANSWER_BITS'(hit_tag);
                end
                OP_FIRST:
                begin
                    if (!found_reg && near_radius)
                    begin
                        found_next  = 1'b1;
                        status_next = ST_OK;
                        answer_next = ANSWER_BITS'(hit_slot);
                    end
                end
                OP_NEAREST:
                begin
                    if (!found_reg || near_best)
                    begin
                        found_next  = 1'b1;
                        best_next   = hit_dist;
                        status_next = ST_OK;
                        answer_next = ANSWER_BITS'(hit_tag);
                    end
                end
                default:
                begin
                    found_next = found_reg;
                end
            endcase
        end
    end

    // Hold state, fill count and radius
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            radius_reg <= RADIUS_RESET;
            found_reg  <= 1'b0;
            issue_reg  <= '0;
            limit_reg  <= '0;
            op_reg     <= OP_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            found_reg <= found_next;
            issue_reg <= issue_next;
            limit_reg <= limit_next;
            op_reg    <= op_next;
            if (cfg.valid && cfg.ready)
            begin
                radius_reg <= cfg.radius_squared;
            end
        end
    end

    // Hold query and running result
    always_ff @(posedge clk)
    begin
        qx_reg     <= qx_next;
        qy_reg     <= qy_next;
        best_reg   <= best_next;
        status_reg <= status_next;
        answer_reg <= answer_next;
    end

    // Response register: load when free or drained, drop on handoff
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (load_rsp)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_rsp)
        begin
            rsp_status_reg <= status_reg;
            rsp_answer_reg <= answer_reg;
        end
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.status = rsp_status_reg;
    assign rsp.answer = rsp_answer_reg;

endmodule
`default_nettype wire

// File: sv/ptns_check.sv
// Port-level checks on the top level, attached by bind.
`default_nettype none
module ptns_check (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             req_valid,
    input wire logic                             req_ready,
    input wire logic                             rsp_valid,
    input wire logic                             rsp_ready,
    input wire logic [ptns_pkg::STATUS_BITS-1:0] rsp_status,
    input wire logic [ptns_pkg::ANSWER_BITS-1:0] rsp_answer
);
    import ptns_pkg::*;

    // One request at a time: ready drops right after a request beat
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in flight");

    // A failed op always reports a zero answer
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_OK) |-> (rsp_answer == '0))
        else $error("nonzero answer with failing status");

    // A stalled response stays up
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // A stalled response keeps its payload
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_answer))
        else $error("response payload changed while stalled");

endmodule

bind point_table_nearest_search ptns_check u_ptns_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_answer (rsp.answer)
);
`default_nettype wire

// File: bench/tb.sv
// Self-checking testbench for the point table nearest search block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptns_pkg::*;

    localparam int CAPACITY      = 4096;
    localparam int COORD_BITS    = 24;
    localparam int TAG_BITS      = 20;
    localparam int SETTLE_CYCLES = 16;
    localparam int FILL_POINTS   = 12;
    localparam int CYCLE_LIMIT   = 3000000;

    localparam logic signed [COORD_BITS-1:0] COORD_MIN = 24'sh800000;
    localparam logic signed [COORD_BITS-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic [SLOT_BITS-1:0]         SLOT_MAX  = '1;
    localparam logic [RADIUS_BITS-1:0]       RADIUS_MAX = 50'd1 << 49;
    localparam logic [OP_BITS-1:0]           OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_BITS-1:0]           OP_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [OP_BITS-1:0]            op;
        logic signed [COORD_BITS-1:0]  x;
        logic signed [COORD_BITS-1:0]  y;
        logic [SLOT_BITS-1:0]          tag_or_slot;
    } req_item_t;

    typedef struct packed {
        status_t                status;
        logic [ANSWER_BITS-1:0] answer;
    } table_answer_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ptns_req_if #(.COORD_BITS(COORD_BITS)) req ();
    ptns_rsp_if rsp ();
    ptns_cfg_if cfg ();

    point_table_nearest_search #(
        .CAPACITY   (CAPACITY),
        .COORD_BITS (COORD_BITS),
        .TAG_BITS   (TAG_BITS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // Shadow copy of the point table and the radius register
    logic signed [COORD_BITS-1:0] tbl_x   [CAPACITY];
    logic signed [COORD_BITS-1:0] tbl_y   [CAPACITY];
    logic [TAG_BITS-1:0]          tbl_tag [CAPACITY];
    int unsigned                  tbl_count = 0;
    logic [RADIUS_BITS-1:0]       radius_sq = RADIUS_RESET;

    req_item_t     pending_requests[$];
    table_answer_t awaited_answers[$];

    int unsigned items_issued   = 0;
    int unsigned responses_seen = 0;
    int unsigned failures       = 0;
    int unsigned radius_writes  = 0;
    int unsigned full_rejects   = 0;
    int unsigned peak_fill      = 0;
    int unsigned fill_planned   = 0;
    int unsigned cycle_count    = 0;
    int unsigned rsp_hold_left  = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;
    bit          req_beat       = 1'b0;

    always #5 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic longint sq_dist(input int slot,
                                       input logic signed [COORD_BITS-1:0] qx,
                                       input logic signed [COORD_BITS-1:0] qy);
        longint dx;
        longint dy;
        dx = longint'(tbl_x[slot]) - longint'(qx);
        dy = longint'(tbl_y[slot]) - longint'(qy);
        return dx * dx + dy * dy;
    endfunction

    // Update the shadow table for one request beat and queue its answer
    task automatic apply_table_op(input req_item_t it);
        table_answer_t want;
        longint        best;
        longint        d;
        want.status = ST_OK;
        want.answer = '0;
        best        = 0;
        case (it.op)
            OP_CLEAR:
                tbl_count = 0;
            OP_INSERT:
                if (tbl_count >= CAPACITY)
                begin
                    want.status = ST_FULL;
                    full_rejects++;
                end
                else
                begin
                    tbl_x[tbl_count]   = it.x;
                    tbl_y[tbl_count]   = it.y;
                    tbl_tag[tbl_count] = it.tag_or_slot[TAG_BITS-1:0];
                    tbl_count++;
                    if (tbl_count > peak_fill)
                        peak_fill = tbl_count;
                end
            OP_READ:
                if (it.tag_or_slot >= tbl_count)
                    want.status = ST_RANGE;
                else
                    want.answer = tbl_tag[it.tag_or_slot];
            OP_FIRST:
            begin
                want.status = ST_NOT_FOUND;
                for (int i = 0; i < tbl_count; i++)
                begin
                    if (sq_dist(i, it.x, it.y) < longint'(radius_sq))
                    begin
                        want.status = ST_OK;
                        want.answer = ANSWER_BITS'(i);
                        break;
                    end
                end
            end
            OP_NEAREST:
            begin
                want.status = (tbl_count != 0) ? ST_OK : ST_NOT_FOUND;
                for (int i = 0; i < tbl_count; i++)
                begin
                    d = sq_dist(i, it.x, it.y);
                    // strict compare keeps the lowest slot on a tie
                    if (i == 0 || d < best)
                    begin
                        best        = d;
                        want.answer = tbl_tag[i];
                    end
                end
            end
            default: ;
        endcase
        awaited_answers = {awaited_answers, want};
    endtask

    // Check response beats, then record request beats
    always @(posedge clk)
    begin : response_monitor
        table_answer_t want;
        req_item_t     seen;
        req_beat = 1'b0;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_answers.size() == 0)
                begin
                    $error("response beat with nothing outstanding: status %0d answer %0h",
                           rsp.status, rsp.answer);
                    failures++;
                end
                else
                begin
                    want = awaited_answers.pop_front();
                    responses_seen++;
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        failures++;
                    end
                    if (rsp.answer !== want.answer)
                    begin
                        $error("answer: expected %0h, got %0h", want.answer, rsp.answer);
                        failures++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                req_beat         = 1'b1;
                seen.op          = req.op;
                seen.x           = req.x_coord;
                seen.y           = req.y_coord;
                seen.tag_or_slot = req.tag_or_slot;
                apply_table_op(seen);
            end
        end
    end

    // Drive request beats; hold the payload until it is taken
    always @(negedge clk)
    begin : request_driver
        req_item_t it;
        if (rst_n && (!req.valid || req_beat))
        begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                it = pending_requests.pop_front();
                req.valid       <= 1'b1;
                req.op          <= it.op;
                req.x_coord     <= it.x;
                req.y_coord     <= it.y;
                req.tag_or_slot <= it.tag_or_slot;
            end
            else
                req.valid <= 1'b0;
        end
    end

    // Throttle the response side; a requested hold-off wins over random stalls
    always @(negedge clk)
    begin
        if (rsp_hold_left != 0)
        begin
            rsp_hold_left--;
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic signed [COORD_BITS-1:0] rand_coord();
        logic [31:0] r;
        r = $urandom;
        return r[COORD_BITS-1:0];
    endfunction

    function automatic logic [SLOT_BITS-1:0] rand_slot();
        logic [31:0] r;
        r = $urandom;
        return r[SLOT_BITS-1:0];
    endfunction

    // Random point around a center, clamped to the coordinate range
    function automatic logic signed [COORD_BITS-1:0] near(
        input logic signed [COORD_BITS-1:0] c, input int spread);
        int v;
        v = int'(c) + int'($urandom_range(2 * spread)) - spread;
        if (v > int'(COORD_MAX))
            v = COORD_MAX;
        if (v < int'(COORD_MIN))
            v = COORD_MIN;
        return v[COORD_BITS-1:0];
    endfunction

    function automatic logic [RADIUS_BITS-1:0] pick_radius();
        logic [63:0] r;
        case ($urandom_range(5))
            0:       return '0;
            1:       return RADIUS_MAX;
            2:       return RADIUS_RESET;
            default:
            begin
                // log-spread value below 2**49
                r = {$urandom, $urandom} >> (15 + $urandom_range(44));
                return r[RADIUS_BITS-1:0];
            end
        endcase
    endfunction

    task automatic send_op(input logic [OP_BITS-1:0] op,
                           input logic signed [COORD_BITS-1:0] x,
                           input logic signed [COORD_BITS-1:0] y,
                           input logic [SLOT_BITS-1:0] tag_or_slot);
        req_item_t it;
        it.op          = op;
        it.x           = x;
        it.y           = y;
        it.tag_or_slot = tag_or_slot;
        pending_requests = {pending_requests, it};
        items_issued++;
        if (op == OP_CLEAR)
            fill_planned = 0;
        else if (op == OP_INSERT && fill_planned < CAPACITY)
            fill_planned++;
    endtask

    // Hold off new requests until every answer is back and the block is idle
    task automatic settle();
        while (responses_seen != items_issued)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_radius(input logic [RADIUS_BITS-1:0] value);
        @(negedge clk);
        cfg.valid          <= 1'b1;
        cfg.radius_squared <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        radius_sq = value;
        radius_writes++;
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        @(posedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Cluster of inserts followed by queries around it
    task automatic random_session();
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        int spread;
        int n_pts;
        int n_q;
        if ($urandom_range(2) == 0)
            send_op(OP_CLEAR, rand_coord(), rand_coord(), rand_slot());
        cx     = rand_coord();
        cy     = rand_coord();
        spread = 1 << $urandom_range(4, 16);
        px     = near(cx, spread);
        py     = near(cy, spread);
        n_pts  = $urandom_range(1, 8);
        for (int i = 0; i < n_pts; i++)
        begin
            // now and then repeat the last point to create distance ties
            if (i == 0 || $urandom_range(3) != 0)
            begin
                px = near(cx, spread);
                py = near(cy, spread);
            end
            send_op(OP_INSERT, px, py, rand_slot());
        end
        n_q = $urandom_range(2, 6);
        for (int i = 0; i < n_q; i++)
        begin
            case ($urandom_range(9))
                0:       send_op(OP_NEAREST, px, py, rand_slot());
                1, 2:    send_op(OP_NEAREST, near(cx, spread), near(cy, spread), rand_slot());
                3:       send_op(OP_FIRST, px, py, rand_slot());
                4, 5:    send_op(OP_FIRST, near(cx, spread), near(cy, spread), rand_slot());
                6:       send_op(OP_READ, rand_coord(), rand_coord(),
                                 SLOT_BITS'($urandom_range(fill_planned + 1)));
                7:       send_op(($urandom_range(1) != 0) ? OP_NEAREST : OP_FIRST,
                                 rand_coord(), rand_coord(), rand_slot());
                8:       send_op(OP_BITS'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                                 rand_coord(), rand_coord(), rand_slot());
                default: send_op(OP_READ, rand_coord(), rand_coord(), rand_slot());
            endcase
        end
    endtask

    task automatic random_run(input int unsigned stop_at);
        while (items_issued < stop_at)
        begin
            random_session();
            if ($urandom_range(2) == 0)
            begin
                settle();
                write_radius(pick_radius());
            end
        end
        settle();
    endtask

    initial
    begin
        logic signed [COORD_BITS-1:0] lx;
        logic signed [COORD_BITS-1:0] ly;
        int unsigned                  mark;

        req.valid          = 1'b0;
        req.op             = OP_CLEAR;
        req.x_coord        = '0;
        req.y_coord        = '0;
        req.tag_or_slot    = '0;
        rsp.ready          = 1'b0;
        cfg.valid          = 1'b0;
        cfg.radius_squared = '0;
        lx                 = '0;
        ly                 = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_idling(38, 69);

        // Directed: empty table, coordinate and tag extremes, ties, range checks
        send_op(OP_NEAREST, '0, '0, '0);
        send_op(OP_FIRST, '0, '0, '0);
        send_op(OP_READ, '0, '0, '0);
        send_op(OP_INSERT, COORD_MIN, COORD_MIN, '0);
        send_op(OP_INSERT, COORD_MAX, COORD_MAX, SLOT_MAX);
        send_op(OP_INSERT, '0, '0, 20'h5A5A5);
        send_op(OP_INSERT, '0, '0, 20'hA5A5A);
        send_op(OP_INSERT, COORD_MIN, COORD_MAX, 20'd1);
        send_op(OP_INSERT, COORD_MAX, COORD_MIN, 20'd2);
        send_op(OP_READ, '0, '0, 20'd0);
        send_op(OP_READ, '0, '0, 20'd5);
        send_op(OP_READ, '0, '0, 20'd6);
        send_op(OP_READ, '0, '0, SLOT_MAX);
        send_op(OP_NEAREST, COORD_MAX, COORD_MAX, '0);
        send_op(OP_NEAREST, 24'sd1, -24'sd1, '0);
        send_op(OP_FIRST, '0, '0, '0);
        send_op(OP_FIRST, COORD_MAX, '0, '0);
        send_op(OP_NEAREST, COORD_MIN, COORD_MIN + 24'sd1, '0);
        for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++)
            send_op(OP_BITS'(c), rand_coord(), rand_coord(), rand_slot());
        send_op(OP_CLEAR, '0, '0, '0);
        send_op(OP_NEAREST, '0, '0, '0);
        send_op(OP_INSERT, 24'sd100, 24'sd100, 20'h12345);
        settle();

        // Zero radius never matches, the largest one matches everything
        write_radius('0);
        send_op(OP_FIRST, 24'sd100, 24'sd100, '0);
        settle();
        write_radius(RADIUS_MAX);
        send_op(OP_FIRST, COORD_MAX, COORD_MAX, '0);
        settle();
        write_radius(RADIUS_RESET);

        mark = items_issued;
        random_run(mark + 40);

        // Fill part of the table, read at its last slot and past it, then scan it
        set_idling(69, 38);
        send_op(OP_CLEAR, '0, '0, '0);
        for (int i = 0; i < FILL_POINTS; i++)
        begin
            lx = rand_coord();
            ly = rand_coord();
            send_op(OP_INSERT, lx, ly, rand_slot());
        end
        send_op(OP_READ, '0, '0, SLOT_BITS'(FILL_POINTS - 1));
        send_op(OP_READ, '0, '0, SLOT_BITS'(FILL_POINTS));
        settle();
        write_radius(50'd1);
        send_op(OP_FIRST, lx, ly, '0);
        send_op(OP_NEAREST, lx, ly, '0);
        send_op(OP_FIRST, rand_coord(), rand_coord(), '0);
        send_op(OP_NEAREST, rand_coord(), rand_coord(), '0);
        send_op(OP_CLEAR, '0, '0, '0);
        settle();

        random_run(mark + 80);

        // Back-pressure: receiver holds off while requests keep coming
        set_idling(0, 0);
        @(posedge clk);
        rsp_hold_left = 400;
        for (int i = 0; i < 12; i++)
        begin
            send_op(OP_INSERT, rand_coord(), rand_coord(), rand_slot());
            send_op(OP_READ, '0, '0, SLOT_BITS'($urandom_range(fill_planned)));
        end
        settle();

        random_run(mark + 115);

        if (awaited_answers.size() != 0)
        begin
            $error("%0d answers never arrived", awaited_answers.size());
            failures++;
        end

        $display("checked %0d request beats across %0d radius writes, peak fill %0d of %0d",
                 responses_seen, radius_writes, peak_fill, CAPACITY);
        $display("overflow inserts rejected: %0d; long receiver hold-off applied once",
                 full_rejects);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
